[rtl/core/mstw_pkg.sv]
// Shared types and constants for the minimum spanning tree weight block.
package mstw_pkg;

  localparam int EP_W   = 8;
  localparam int WT_W   = 16;
  localparam int KEY_W  = 17;
  localparam int SUM_W  = 24;
  localparam int RCH_W  = 9;
  localparam int VC_W   = 9;
  localparam int ST_W   = 2;
  localparam int EDGE_W = 2 * EP_W + WT_W;

  localparam logic [KEY_W-1:0] KEY_NONE = 17'h10000;
  localparam logic [SUM_W-1:0] SUM_MAX  = 24'hFFFFFF;
  localparam logic [RCH_W-1:0] RCH_MAX  = 9'd511;

  localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
  localparam logic [ST_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [ST_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_INIT  = 7'b0000010,
    S_RLX_E = 7'b0000100,
    S_RLX_K = 7'b0001000,
    S_RLX_W = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_PICK  = 7'b1000000
  } state_t;

endpackage

[rtl/core/mstw_if.sv]
// Channel interfaces: edge/run input, result output, configuration write.
interface mstw_in_if import mstw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            kind;
  logic [EP_W-1:0] end_a;
  logic [EP_W-1:0] end_b;
  logic [WT_W-1:0] edge_weight;
  modport source (output valid, kind, end_a, end_b, edge_weight, input ready);
  modport sink   (input valid, kind, end_a, end_b, edge_weight, output ready);
endinterface

interface mstw_out_if import mstw_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] total_weight;
  logic [RCH_W-1:0] reached;
  logic [ST_W-1:0]  status;
  modport source (output valid, total_weight, reached, status, input ready);
  modport sink   (input valid, total_weight, reached, status, output ready);
endinterface

interface mstw_cfg_if import mstw_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VC_W-1:0] vertex_count;
  modport source (output valid, vertex_count, input ready);
  modport sink   (input valid, vertex_count, output ready);
endinterface

[rtl/core/mstw_ram.sv]
// Generic simple dual-port RAM with registered read.
module mstw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/core/min_spanning_tree_weight.sv]
// Top level: edge store and Prim tree growth over a vertex key memory.
// Load beat: accepted one per cycle back to back while the block is idle (no run in progress).
// Run beat: init writes all MAX_VERTICES key entries, then per pass (vertex 0, then each joined
// vertex) an edge-store walk over the stored edges and a key scan over the n live vertices.
// Result held in an output register; input stalls until it can be loaded there.
// Sync reset clears edge count, drop flags and control; vertex_count resets to 256.
module min_spanning_tree_weight import mstw_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  parameter int MAX_EDGES    = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  mstw_in_if.sink     in_ch,
  mstw_out_if.source  out_ch,
  mstw_cfg_if.sink    cfg_ch
);
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = VW + 1;
  localparam int CW = (NW > VC_W) ? NW : VC_W;
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);
  localparam int KR_W = KEY_W + 1;

  state_t           state_r, state_nxt;
  logic [VC_W-1:0]  vc_r;
  logic [EW-1:0]    etot_r, etot_nxt;
  logic [1:0]       flags_r, flags_nxt;
  logic [EW-1:0]    ei_r, ei_nxt;
  logic [NW-1:0]    iv_r, iv_nxt;
  logic [CW-1:0]    sv_r, sv_nxt;
  logic             rdv_r, rdv_nxt;
  logic [VW-1:0]    rdi_r, rdi_nxt;
  logic [VW-1:0]    cur_r, cur_nxt;
  logic [VW-1:0]    oth_r, oth_nxt;
  logic [KEY_W-1:0] best_r, best_nxt;
  logic [VW-1:0]    pick_r, pick_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [RCH_W-1:0] rch_r, rch_nxt;
  logic             ov_r, ov_nxt;
  logic [SUM_W-1:0] otw_r, otw_nxt;
  logic [RCH_W-1:0] orc_r, orc_nxt;
  logic [ST_W-1:0]  ost_r, ost_nxt;

  logic [CW-1:0]    n_eff, a_in, b_in, a_st, b_st, cur_x;
  logic             e_we, e_re, k_we, k_re;
  logic [AW-1:0]    e_waddr, e_raddr;
  logic [EDGE_W-1:0] e_wdata, e_rdata;
  logic [VW-1:0]    k_waddr, k_raddr;
  logic [KR_W-1:0]  k_wdata, k_rdata;
  logic [EP_W-1:0]  st_a, st_b;
  logic [WT_W-1:0]  st_w;
  logic [SUM_W:0]   sum_add;

  mstw_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .re(e_re), .raddr(e_raddr), .rdata(e_rdata)
  );

  mstw_ram #(.WIDTH(KR_W), .DEPTH(MAX_VERTICES)) u_key_ram (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .re(k_re), .raddr(k_raddr), .rdata(k_rdata)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = ov_r;
  assign out_ch.total_weight = otw_r;
  assign out_ch.reached      = orc_r;
  assign out_ch.status       = ost_r;

  always_comb begin
    n_eff = CW'(vc_r);
    if (vc_r == '0) begin
      n_eff = CW'(1);
    end else if (CW'(vc_r) > CW'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end
  end

  assign {st_a, st_b, st_w} = e_rdata;
  assign a_in  = CW'(in_ch.end_a);
  assign b_in  = CW'(in_ch.end_b);
  assign a_st  = CW'(st_a);
  assign b_st  = CW'(st_b);
  assign cur_x = CW'(cur_r);
  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(best_r);

  always_comb begin
    state_nxt = state_r;
    etot_nxt  = etot_r;
    flags_nxt = flags_r;
    ei_nxt    = ei_r;
    iv_nxt    = iv_r;
    sv_nxt    = sv_r;
    rdv_nxt   = 1'b0;
    rdi_nxt   = rdi_r;
    cur_nxt   = cur_r;
    oth_nxt   = oth_r;
    best_nxt  = best_r;
    pick_nxt  = pick_r;
    sum_nxt   = sum_r;
    rch_nxt   = rch_r;
    ov_nxt    = ov_r && !out_ch.ready;
    otw_nxt   = otw_r;
    orc_nxt   = orc_r;
    ost_nxt   = ost_r;
    e_we      = 1'b0;
    e_waddr   = etot_r[AW-1:0];
    e_wdata   = {in_ch.end_a, in_ch.end_b, in_ch.edge_weight};
    e_re      = 1'b0;
    e_raddr   = ei_r[AW-1:0];
    k_we      = 1'b0;
    k_waddr   = oth_r;
    k_wdata   = {1'b0, KEY_NONE};
    k_re      = 1'b0;
    k_raddr   = sv_r[VW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.kind) begin
            iv_nxt    = '0;
            state_nxt = S_INIT;
          end else if (a_in >= n_eff || b_in >= n_eff) begin
            flags_nxt[1] = 1'b1;
          end else if (etot_r >= EW'(MAX_EDGES)) begin
            flags_nxt[0] = 1'b1;
          end else begin
            e_we     = 1'b1;
            etot_nxt = etot_r + EW'(1);
          end
        end
      end
      S_INIT: begin
        k_we    = 1'b1;
        k_waddr = iv_r[VW-1:0];
        k_wdata = {(iv_r == '0), KEY_NONE};
        iv_nxt  = iv_r + NW'(1);
        if (iv_r == NW'(MAX_VERTICES - 1)) begin
          cur_nxt   = '0;
          sum_nxt   = '0;
          rch_nxt   = RCH_W'(1);
          ei_nxt    = '0;
          state_nxt = S_RLX_E;
        end
      end
      S_RLX_E: begin
        if (ei_r == etot_r) begin
          sv_nxt    = '0;
          best_nxt  = KEY_NONE;
          state_nxt = S_SCAN;
        end else begin
          e_re      = 1'b1;
          state_nxt = S_RLX_K;
        end
      end
      S_RLX_K: begin
        k_raddr = '0;
        if (a_st < n_eff && b_st < n_eff && (a_st == cur_x || b_st == cur_x)) begin
          oth_nxt   = (a_st == cur_x) ? b_st[VW-1:0] : a_st[VW-1:0];
          k_raddr   = (a_st == cur_x) ? b_st[VW-1:0] : a_st[VW-1:0];
          k_re      = 1'b1;
          state_nxt = S_RLX_W;
        end else begin
          ei_nxt    = ei_r + EW'(1);
          state_nxt = S_RLX_E;
        end
      end
      S_RLX_W: begin
        if (!k_rdata[KEY_W] && KEY_W'(st_w) < k_rdata[KEY_W-1:0]) begin
          k_we    = 1'b1;
          k_wdata = {1'b0, KEY_W'(st_w)};
        end
        ei_nxt    = ei_r + EW'(1);
        state_nxt = S_RLX_E;
      end
      S_SCAN: begin
        if (sv_r < n_eff) begin
          k_re    = 1'b1;
          rdv_nxt = 1'b1;
          rdi_nxt = sv_r[VW-1:0];
          sv_nxt  = sv_r + CW'(1);
        end else if (!rdv_r) begin
          state_nxt = S_PICK;
        end
        if (rdv_r && !k_rdata[KEY_W] && k_rdata[KEY_W-1:0] < best_r) begin
          best_nxt = k_rdata[KEY_W-1:0];
          pick_nxt = rdi_r;
        end
      end
      S_PICK: begin
        if (best_r != KEY_NONE) begin
          k_we      = 1'b1;
          k_waddr   = pick_r;
          k_wdata   = {1'b1, best_r};
          cur_nxt   = pick_r;
          sum_nxt   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          rch_nxt   = (rch_r < RCH_MAX) ? rch_r + RCH_W'(1) : rch_r;
          ei_nxt    = '0;
          state_nxt = S_RLX_E;
        end else if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          otw_nxt   = sum_r;
          orc_nxt   = rch_r;
          ost_nxt   = flags_r[1] ? STAT_RANGE : (flags_r[0] ? STAT_FULL : STAT_OK);
          etot_nxt  = '0;
          flags_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      vc_r    <= VC_W'(256);
      etot_r  <= '0;
      flags_r <= '0;
      rdv_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        vc_r <= cfg_ch.vertex_count;
      end
      etot_r  <= etot_nxt;
      flags_r <= flags_nxt;
      rdv_r   <= rdv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ei_r   <= ei_nxt;
    iv_r   <= iv_nxt;
    sv_r   <= sv_nxt;
    rdi_r  <= rdi_nxt;
    cur_r  <= cur_nxt;
    oth_r  <= oth_nxt;
    best_r <= best_nxt;
    pick_r <= pick_nxt;
    sum_r  <= sum_nxt;
    rch_r  <= rch_nxt;
    otw_r  <= otw_nxt;
    orc_r  <= orc_nxt;
    ost_r  <= ost_nxt;
  end
endmodule

[tb/sv/min_spanning_tree_weight_test.sv]
// Testbench: random and directed graphs checked against a Prim's-rule spanning tree predictor.
`timescale 1ns / 1ps

module min_spanning_tree_weight_test import mstw_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 400000;
  localparam int STORE_DEPTH    = 1024;
  localparam int VERT_LIMIT     = 256;

  typedef struct {
    logic [SUM_W-1:0] total_weight;
    logic [RCH_W-1:0] reached;
    logic [ST_W-1:0]  status;
  } tree_result_t;

  class mst_scoreboard;
    logic [EP_W-1:0]  edge_a[$];
    logic [EP_W-1:0]  edge_b[$];
    logic [WT_W-1:0]  edge_w[$];
    logic [1:0]       drop_flags;
    logic [VC_W-1:0]  vertex_count;
    bit               joined[VERT_LIMIT];
    int               key[VERT_LIMIT];
    tree_result_t     tree_q[$];
    int               errors;

    function new();
      drop_flags   = 2'b00;
      vertex_count = 9'd256;
      errors       = 0;
    endfunction

    function int live_count();
      if (vertex_count == 0) return 1;
      if (vertex_count > VERT_LIMIT) return VERT_LIMIT;
      return int'(vertex_count);
    endfunction

    function void relax(int v, int n);
      int other;
      for (int i = 0; i < edge_a.size(); i++) begin
        if (edge_a[i] >= n || edge_b[i] >= n) continue;
        if (edge_a[i] == v) other = int'(edge_b[i]);
        else if (edge_b[i] == v) other = int'(edge_a[i]);
        else continue;
        if (!joined[other] && edge_w[i] < key[other]) key[other] = int'(edge_w[i]);
      end
    endfunction

    function void note_beat(logic kind, logic [EP_W-1:0] a, logic [EP_W-1:0] b,
                            logic [WT_W-1:0] w);
      int n;
      int sum;
      int reached;
      int pick;
      int best;
      tree_result_t r;
      n = live_count();
      if (kind == 1'b0) begin
        if (a >= n || b >= n) drop_flags[1] = 1'b1;
        else if (edge_a.size() >= STORE_DEPTH) drop_flags[0] = 1'b1;
        else begin
          edge_a = {edge_a, a};
          edge_b = {edge_b, b};
          edge_w = {edge_w, w};
        end
        return;
      end
      for (int v = 0; v < VERT_LIMIT; v++) begin
        joined[v] = 0;
        key[v]    = 65536;
      end
      joined[0] = 1;
      sum       = 0;
      reached   = 1;
      relax(0, n);
      forever begin
        pick = n;
        best = 65536;
        for (int v = 0; v < n; v++)
          if (!joined[v] && key[v] < best) begin
            best = key[v];
            pick = v;
          end
        if (pick >= n) break;
        joined[pick] = 1;
        sum = (sum + best > 24'hFFFFFF) ? 24'hFFFFFF : sum + best;
        if (reached < 511) reached++;
        relax(pick, n);
      end
      r.total_weight = SUM_W'(sum);
      r.reached      = RCH_W'(reached);
      r.status       = drop_flags[1] ? STAT_RANGE : (drop_flags[0] ? STAT_FULL : STAT_OK);
      tree_q = {tree_q, r};
      edge_a.delete();
      edge_b.delete();
      edge_w.delete();
      drop_flags = 2'b00;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [SUM_W-1:0] tw, logic [RCH_W-1:0] rc, logic [ST_W-1:0] st);
      tree_result_t e;
      if (tree_q.size() == 0) begin
        report($sformatf("unexpected result tw=%0d reached=%0d status=%0d", tw, rc, st));
        return;
      end
      e = tree_q.pop_front();
      if (tw !== e.total_weight)
        report($sformatf("total_weight %0d, expected %0d", tw, e.total_weight));
      if (rc !== e.reached)
        report($sformatf("reached %0d, expected %0d", rc, e.reached));
      if (st !== e.status)
        report($sformatf("status %0d, expected %0d", st, e.status));
    endtask
  endclass

  logic clk;
  logic rst_n;

  mstw_in_if  in_ch();
  mstw_out_if out_ch();
  mstw_cfg_if cfg_ch();

  min_spanning_tree_weight u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  mst_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_len;
  int quiet_cycles;
  int items_sent;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls plus a long hold-off whenever hold_len is set
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.total_weight, out_ch.reached, out_ch.status);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task send_beat(logic kind, logic [EP_W-1:0] a, logic [EP_W-1:0] b, logic [WT_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= kind;
    in_ch.end_a       <= a;
    in_ch.end_b       <= b;
    in_ch.edge_weight <= w;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(kind, a, b, w);
    items_sent++;
  endtask

  task run_tree();
    send_beat(1'b1, EP_W'($urandom), EP_W'($urandom), WT_W'($urandom));
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.tree_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task write_vertex_count(logic [VC_W-1:0] v);
    drain();
    cfg_ch.valid        <= 1'b1;
    cfg_ch.vertex_count <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.vertex_count = v;
  endtask

  task set_pace(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
      default: begin send_idle_pct = 32; recv_stall_pct = 32; end
    endcase
  endtask

  function logic [WT_W-1:0] pick_weight();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 16'h0000;
    if (sel < 20) return 16'hFFFF;
    if (sel < 50) return WT_W'($urandom_range(15));
    return WT_W'($urandom);
  endfunction

  task random_graph();
    int n;
    int m;
    int sel;
    logic [VC_W-1:0] vc;
    sel = $urandom_range(99);
    if (sel < 55) vc = VC_W'($urandom_range(12, 2));
    else if (sel < 70) vc = VC_W'($urandom_range(40, 13));
    else if (sel < 80) vc = 9'd256;
    else if (sel < 86) vc = 9'd1;
    else if (sel < 92) vc = 9'd0;
    else vc = VC_W'($urandom_range(511, 257));
    write_vertex_count(vc);
    n = sb.live_count();
    m = $urandom_range(24);
    for (int i = 0; i < m; i++) begin
      if ($urandom_range(99) < 90)
        send_beat(1'b0, EP_W'($urandom_range(n - 1)), EP_W'($urandom_range(n - 1)),
                  pick_weight());
      else
        send_beat(1'b0, EP_W'($urandom), EP_W'($urandom), pick_weight());
    end
    run_tree();
  endtask

  initial begin
    sb             = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 0;
    quiet_cycles   = 0;
    items_sent     = 0;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= 1'b0;
    in_ch.end_a         <= '0;
    in_ch.end_b         <= '0;
    in_ch.edge_weight   <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.vertex_count <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset count, field extremes, self loop, equal keys
    send_beat(1'b0, 8'd0, 8'd255, 16'hFFFF);
    send_beat(1'b0, 8'd255, 8'd0, 16'h0000);
    send_beat(1'b0, 8'd3, 8'd3, 16'd7);
    send_beat(1'b0, 8'd1, 8'd2, 16'd5);
    send_beat(1'b0, 8'd0, 8'd1, 16'd5);
    send_beat(1'b0, 8'd0, 8'd2, 16'd5);
    run_tree();
    run_tree();
    // endpoint out of range
    write_vertex_count(9'd4);
    send_beat(1'b0, 8'd4, 8'd0, 16'd1);
    send_beat(1'b0, 8'd0, 8'd3, 16'd9);
    run_tree();
    // zero count acts as one
    write_vertex_count(9'd0);
    send_beat(1'b0, 8'd0, 8'd0, 16'd3);
    send_beat(1'b0, 8'd1, 8'd0, 16'd3);
    run_tree();
    // count above the limit, then lowered after loading
    write_vertex_count(9'd511);
    send_beat(1'b0, 8'd0, 8'd200, 16'd3);
    send_beat(1'b0, 8'd0, 8'd1, 16'd4);
    send_beat(1'b0, 8'd1, 8'd99, 16'd8);
    write_vertex_count(9'd100);
    run_tree();
    // store full, then store full with a range drop
    write_vertex_count(9'd2);
    for (int i = 0; i < STORE_DEPTH + 1; i++) send_beat(1'b0, 8'd0, 8'd1, WT_W'($urandom));
    run_tree();
    for (int i = 0; i < STORE_DEPTH + 1; i++) send_beat(1'b0, 8'd1, 8'd0, WT_W'($urandom));
    send_beat(1'b0, 8'd5, 8'd0, 16'd1);
    run_tree();

    items_sent = 0;
    for (int g = 0; items_sent < 400; g++) begin
      set_pace(g / 3);
      if (g == 6) begin
        // long receiver hold-off while graphs keep coming
        drain();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len       = 1500;
        for (int k = 0; k < 4; k++) begin
          for (int i = 0; i < 5; i++)
            send_beat(1'b0, EP_W'($urandom_range(7)), EP_W'($urandom_range(7)),
                      pick_weight());
          run_tree();
        end
      end
      random_graph();
    end

    drain();
    repeat (200) @(posedge clk);
    if (sb.tree_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.tree_q.size()));
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[files.f]
rtl/core/mstw_pkg.sv
rtl/core/mstw_if.sv
rtl/core/mstw_ram.sv
rtl/core/min_spanning_tree_weight.sv
tb/sv/min_spanning_tree_weight_test.sv
